// ----- hw/rtl/diffusion_quadrature_data_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the diffusion quadrature data block
// Shared forms for the concurrent checks, clocked on aclk with reset masking.
// ---------------------------------------------------------------------------
`ifndef DIFFUSION_QUADRATURE_DATA_ASSERT_SVH
`define DIFFUSION_QUADRATURE_DATA_ASSERT_SVH

// Same-cycle implication.
`define DQD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dqd_pkg.sv -----
// ---------------------------------------------------------------------------
// Diffusion quadrature data package
// Register indexes and dimension codes shared by the block.
// ---------------------------------------------------------------------------
package dqd_pkg;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DIMENSION        = 2'd0;
    localparam cfg_idx_t REG_COEFF_FROM_POINT = 2'd1;
    localparam cfg_idx_t REG_CONSTANT_COEFF   = 2'd2;

    typedef logic [1:0] dim_t;

    localparam dim_t DIM_2D = 2'd2;
    localparam dim_t DIM_3D = 2'd3;

    localparam dim_t       DIMENSION_RESET = DIM_3D;
    localparam logic [31:0] COEFF_RESET    = 32'd65536;

endpackage

// ----- hw/rtl/dqd_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a sideband
// that travels alongside the operands.
// ---------------------------------------------------------------------------
module dqd_div #(
    parameter int W  = 32,
    parameter int NB = 48,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NB-1:0] num,
    input  logic [W-1:0]  den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NB-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [NB];
    logic [W-1:0]  rem_reg  [NB];
    logic [NB-1:0] num_reg  [NB];
    logic [NB-1:0] q_reg    [NB];
    logic [W-1:0]  den_reg  [NB];
    logic [SW-1:0] side_reg [NB];

    for (genvar s = 0; s < NB; s++) begin : g_stage
        logic          vld_in;
        logic [W-1:0]  rem_in;
        logic [NB-1:0] num_in;
        logic [NB-1:0] q_in;
        logic [W-1:0]  den_in;
        logic [SW-1:0] side_in;
        logic [W:0]    shifted;
        logic [W:0]    diff;
        logic          take;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign num_in  = num;
            assign q_in    = '0;
            assign den_in  = den;
            assign side_in = side;
        end else begin : g_next
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign num_in  = num_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign shifted = {rem_in, num_in[NB-1-s]};
        assign diff    = shifted - {1'b0, den_in};
        assign take    = (shifted >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= take ? diff[W-1:0] : shifted[W-1:0];
                q_reg[s]    <= q_in | (take ? (NB'(1) << (NB - 1 - s)) : '0);
                num_reg[s]  <= num_in;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NB-1];
    assign quo       = q_reg[NB-1];
    assign side_out  = side_reg[NB-1];

endmodule

// ----- hw/rtl/diffusion_quadrature_data.sv -----
// ---------------------------------------------------------------------------
// Diffusion quadrature data
// Builds coeff * weight / det(J) * adj(J) * adj(J)^T per quadrature point.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  cfg     | in        | cfg_index, cfg_data
//  s       | in        | Jacobian, quadrature weight, point coefficient, last
//  m       | out       | six symmetric entries, singular, last
//
// One point enters per cycle unless the pipeline is frozen; the divider
// yields one quotient bit per stage.
// Reset clears stage valid bits and loads the register defaults.
// A waiting result with m_ready low freezes the whole pipeline.
// ---------------------------------------------------------------------------
`include "diffusion_quadrature_data_assert.svh"

module diffusion_quadrature_data
    import dqd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_jac_11,
    input  logic signed [31:0] s_jac_21,
    input  logic signed [31:0] s_jac_31,
    input  logic signed [31:0] s_jac_12,
    input  logic signed [31:0] s_jac_22,
    input  logic signed [31:0] s_jac_32,
    input  logic signed [31:0] s_jac_13,
    input  logic signed [31:0] s_jac_23,
    input  logic signed [31:0] s_jac_33,
    input  logic signed [31:0] s_quad_weight,
    input  logic signed [31:0] s_point_coeff,
    input  logic        s_batch_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_sym_0,
    output logic signed [31:0] m_sym_1,
    output logic signed [31:0] m_sym_2,
    output logic signed [31:0] m_sym_3,
    output logic signed [31:0] m_sym_4,
    output logic signed [31:0] m_sym_5,
    output logic        m_singular,
    output logic        m_result_last
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = 2 * W + F;
    localparam int NB = W + F;

    typedef logic signed [W-1:0] word_t;

    typedef struct packed {
        logic            sign;
        logic            sing;
        logic            last;
        word_t           c;
        logic [5:0][W-1:0] e;
    } side_t;

    localparam int SW = $bits(side_t);

    localparam word_t MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam word_t MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};
    localparam int ROW_A [6] = '{0, 0, 0, 1, 1, 2};
    localparam int ROW_B [6] = '{0, 1, 2, 1, 2, 2};

    function automatic logic [W-1:0] umag(input word_t v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic word_t from_mag(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] lim;
        word_t         r;
        lim = MW'(1) << (W - 1);
        if (!neg) begin
            r = (m >= lim) ? MAX_W : word_t'(m[W-1:0]);
        end else if (m >= lim) begin
            r = MIN_W;
        end else begin
            r = -word_t'(m[W-1:0]);
        end
        return r;
    endfunction

    function automatic word_t fmul(input word_t a, input word_t b);
        logic [2*W-1:0] p;
        p = umag(a) * umag(b);
        return from_mag(a[W-1] ^ b[W-1], MW'(p >> F));
    endfunction

    function automatic word_t clamp1(input logic signed [W:0] s);
        word_t r;
        if (s[W] != s[W-1]) begin
            r = s[W] ? MIN_W : MAX_W;
        end else begin
            r = s[W-1:0];
        end
        return r;
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        return clamp1({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic word_t ssub(input word_t a, input word_t b);
        return clamp1({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic word_t sneg(input word_t v);
        return (v == MIN_W) ? MAX_W : -v;
    endfunction

    function automatic word_t load(input logic signed [31:0] x);
        logic signed [65:0] xe;
        word_t              r;
        xe = 66'(x);
        if (xe > 66'(MAX_W)) begin
            r = MAX_W;
        end else if (xe < 66'(MIN_W)) begin
            r = MIN_W;
        end else begin
            r = xe[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] store(input word_t v);
        logic signed [65:0] ve;
        logic [31:0]        r;
        ve = 66'(v);
        if (ve > S32_MAX) begin
            r = S32_MAX[31:0];
        end else if (ve < S32_MIN) begin
            r = S32_MIN[31:0];
        end else begin
            r = ve[31:0];
        end
        return r;
    endfunction

    // Configuration registers
    dim_t        dimension_reg;
    logic        coeff_from_point_reg;
    logic [31:0] constant_coeff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dimension_reg        <= DIMENSION_RESET;
            coeff_from_point_reg <= 1'b0;
            constant_coeff_reg   <= COEFF_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DIMENSION:        dimension_reg        <= cfg_data[1:0];
                REG_COEFF_FROM_POINT: coeff_from_point_reg <= cfg_data[0];
                REG_CONSTANT_COEFF:   constant_coeff_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic  en;
    logic  m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 1: load and adjugate products
    logic  v1_reg;
    word_t j1_reg [9];
    word_t qw1_reg, c1_reg, cq1_reg;
    logic  last1_reg;
    word_t pp1_reg [18];

    word_t jl [9];
    word_t cl, qwl;

    always_comb begin
        jl[0] = load(s_jac_11);
        jl[1] = load(s_jac_12);
        jl[2] = load(s_jac_13);
        jl[3] = load(s_jac_21);
        jl[4] = load(s_jac_22);
        jl[5] = load(s_jac_23);
        jl[6] = load(s_jac_31);
        jl[7] = load(s_jac_32);
        jl[8] = load(s_jac_33);
        qwl   = load(s_quad_weight);
        cl    = coeff_from_point_reg ? load(s_point_coeff) : load(constant_coeff_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                j1_reg[i] <= jl[i];
            end
            for (int k = 0; k < 18; k++) begin
                pp1_reg[k] <= fmul(jl[PA[k]], jl[PB[k]]);
            end
            qw1_reg   <= qwl;
            c1_reg    <= cl;
            cq1_reg   <= fmul(cl, qwl);
            last1_reg <= s_batch_last;
        end
    end

    // Stage 2: adjugate entries
    logic  v2_reg;
    word_t j2_reg [9];
    word_t qw2_reg, c2_reg, cq2_reg;
    logic  last2_reg;
    word_t a2_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                j2_reg[i] <= j1_reg[i];
                a2_reg[i] <= ssub(pp1_reg[2*i], pp1_reg[2*i+1]);
            end
            qw2_reg   <= qw1_reg;
            c2_reg    <= c1_reg;
            cq2_reg   <= cq1_reg;
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: entry and determinant products
    logic  v3_reg;
    word_t j11_3_reg, a33_3_reg, qw3_reg, c3_reg, cq3_reg;
    logic  last3_reg;
    word_t ep3_reg [6][3];
    word_t dp3_reg [3];

    word_t ox [6][3];
    word_t oy [6][3];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            for (int t = 0; t < 3; t++) begin
                if (dimension_reg == DIM_3D) begin
                    ox[k][t] = a2_reg[ROW_A[k]*3 + t];
                    oy[k][t] = a2_reg[ROW_B[k]*3 + t];
                end else begin
                    ox[k][t] = '0;
                    oy[k][t] = '0;
                end
            end
        end
        if (dimension_reg == DIM_2D) begin
            for (int t = 0; t < 2; t++) begin
                ox[0][t] = j2_reg[3*t + 1];
                oy[0][t] = j2_reg[3*t + 1];
                ox[1][t] = j2_reg[3*t];
                oy[1][t] = j2_reg[3*t + 1];
                ox[2][t] = j2_reg[3*t];
                oy[2][t] = j2_reg[3*t];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                for (int t = 0; t < 3; t++) begin
                    ep3_reg[k][t] <= fmul(ox[k][t], oy[k][t]);
                end
            end
            for (int t = 0; t < 3; t++) begin
                dp3_reg[t] <= fmul(j2_reg[3*t], a2_reg[t]);
            end
            j11_3_reg <= j2_reg[0];
            a33_3_reg <= a2_reg[8];
            qw3_reg   <= qw2_reg;
            c3_reg    <= c2_reg;
            cq3_reg   <= cq2_reg;
            last3_reg <= last2_reg;
        end
    end

    // Stage 4: sums, determinant and divider operands
    logic          v4_reg;
    logic [NB-1:0] num4_reg;
    logic [W-1:0]  den4_reg;
    side_t         side4_reg;

    word_t numer, denom;
    side_t side_next;

    always_comb begin
        side_next = '0;
        for (int k = 0; k < 6; k++) begin
            side_next.e[k] = sadd(sadd(ep3_reg[k][0], ep3_reg[k][1]), ep3_reg[k][2]);
        end
        if (dimension_reg == DIM_3D) begin
            denom = sadd(sadd(dp3_reg[0], dp3_reg[1]), dp3_reg[2]);
            numer = qw3_reg;
        end else if (dimension_reg == DIM_2D) begin
            denom = a33_3_reg;
            numer = qw3_reg;
        end else begin
            denom = j11_3_reg;
            numer = cq3_reg;
        end
        side_next.sign = numer[W-1] ^ denom[W-1];
        side_next.sing = (denom == '0);
        side_next.last = last3_reg;
        side_next.c    = c3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg  <= {umag(numer), {F{1'b0}}};
            den4_reg  <= umag(denom);
            side4_reg <= side_next;
        end
    end

    // Divider
    logic          dv_valid;
    logic [NB-1:0] dv_quo;
    logic [SW-1:0] dv_side;
    side_t         side_d;

    dqd_div #(
        .W  (W),
        .NB (NB),
        .SW (SW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .num       (num4_reg),
        .den       (den4_reg),
        .side      (side4_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    assign side_d = side_t'(dv_side);

    // Stage 5: weight times coefficient
    logic  v5_reg;
    word_t w5_reg, cw5_reg;
    logic  sing5_reg, last5_reg;
    word_t e5_reg [6];

    word_t wq;

    assign wq = from_mag(side_d.sign, MW'(dv_quo));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w5_reg    <= wq;
            cw5_reg   <= fmul(side_d.c, wq);
            sing5_reg <= side_d.sing;
            last5_reg <= side_d.last;
            for (int k = 0; k < 6; k++) begin
                e5_reg[k] <= side_d.e[k];
            end
        end
    end

    // Stage 6: output register
    logic [31:0] sym_reg [6];
    logic        m_singular_reg, m_result_last_reg;
    logic [31:0] sym_next [6];
    word_t       r [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            r[k] = fmul(cw5_reg, e5_reg[k]);
        end
        if (dimension_reg == DIM_2D) begin
            r[1] = sneg(r[1]);
            for (int k = 3; k < 6; k++) begin
                r[k] = '0;
            end
        end else if (dimension_reg != DIM_3D) begin
            r[0] = w5_reg;
            for (int k = 1; k < 6; k++) begin
                r[k] = '0;
            end
        end
        for (int k = 0; k < 6; k++) begin
            sym_next[k] = sing5_reg ? 32'd0 : store(r[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                sym_reg[k] <= sym_next[k];
            end
            m_singular_reg    <= sing5_reg;
            m_result_last_reg <= last5_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sym_0       = sym_reg[0];
    assign m_sym_1       = sym_reg[1];
    assign m_sym_2       = sym_reg[2];
    assign m_sym_3       = sym_reg[3];
    assign m_sym_4       = sym_reg[4];
    assign m_sym_5       = sym_reg[5];
    assign m_singular    = m_singular_reg;
    assign m_result_last = m_result_last_reg;

    logic upper_zero;
    logic sym_zero;

    assign upper_zero = (sym_reg[3] == 32'd0) && (sym_reg[4] == 32'd0)
                     && (sym_reg[5] == 32'd0);
    assign sym_zero   = upper_zero && (sym_reg[0] == 32'd0) && (sym_reg[1] == 32'd0)
                     && (sym_reg[2] == 32'd0);

    `DQD_ASSERT_IMPLY(a_singular_zero, m_valid_reg && m_singular_reg, sym_zero, "Singular transfer carries nonzero entries.")
    `DQD_ASSERT_IMPLY(a_unused_zero, m_valid_reg && (dimension_reg != DIM_3D), upper_zero, "Unused entries are nonzero.")
    `DQD_ASSERT_NEXT(a_last_stage_moves, v5_reg && en, m_valid_reg, "A point did not reach the output.")

endmodule
